@@ hdl/assert_macros.svh @@
// Assertion helpers; clocked on clk, masked while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define RDD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RDD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rdd_pkg.sv @@
`timescale 1ns / 1ps
package rdd_pkg;

	typedef enum logic [2:0] {
		PhLead, PhSkip, PhHeader, PhBegin, PhPayload, PhCookie, PhEndmark, PhDone
	} phase_t;

	typedef enum logic [2:0] {
		StOk, StBadLead, StTooShort, StBadHeader, StNoBegin, StNoCookie, StNoEnd, StBadLength
	} status_t;

	localparam logic KindPayload = 1'b0;
	localparam logic KindStatus  = 1'b1;

	localparam logic [7:0]  LeadByte          = 8'h60;
	localparam logic [7:0]  HeaderTag         = 8'h58;
	localparam logic [7:0]  BeginTag          = 8'hbb;
	localparam logic [7:0]  EndTag            = 8'hee;
	localparam logic [31:0] EndCookie         = 32'h87654321;
	localparam logic [15:0] MinDatagramBytes  = 16'd19;
	localparam logic [16:0] MaxDatagramBytes  = 17'd65535;
	localparam logic [15:0] FrameOverhead     = 16'd3;
	localparam logic [13:0] MinWordsForFrame  = 14'd4;
	localparam logic [1:0]  SkipLastPos       = 2'd2;
	localparam logic [1:0]  WordLastPos       = 2'd3;
	localparam logic [11:0] FrameCountMax     = 12'hfff;

	// One queued result, before formatting at the output.
	// For a status item, index carries the frame count.
	typedef struct packed {
		logic        kind;
		logic [31:0] word;
		logic [11:0] index;
		logic        last;
		status_t     status;
	} res_t;

endpackage

@@ hdl/rdd_byte_if.sv @@
`timescale 1ns / 1ps
interface rdd_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] datagram_bytes;
	logic        last_byte;

	modport source (output valid, data_byte, datagram_bytes, last_byte, input ready);
	modport sink   (input valid, data_byte, datagram_bytes, last_byte, output ready);
endinterface

@@ hdl/rdd_result_if.sv @@
`timescale 1ns / 1ps
interface rdd_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] payload_word;
	logic [11:0] readout_index;
	logic        last_in_readout;
	logic [2:0]  status;
	logic [11:0] readout_count;

	modport source (output valid, kind, payload_word, readout_index, last_in_readout,
		status, readout_count, input ready);
	modport sink   (input valid, kind, payload_word, readout_index, last_in_readout,
		status, readout_count, output ready);
endinterface

@@ hdl/rdd_parser.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdd_parser (
	input  logic          clk,
	input  logic          arst_n,
	rdd_byte_if.sink      bytes,
	output logic          push,
	output rdd_pkg::res_t push_data,
	input  logic          full
);
	import rdd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  bp_q, bp_d;
	logic [23:0] wa_q, wa_d;
	logic [13:0] wr_q, wr_d;
	logic [15:0] pr_q, pr_d;
	logic [11:0] ff_q, ff_d;
	status_t     err_q, err_d;
	logic        pend_q;
	res_t        pend_data_q;

	logic        accept;
	logic [31:0] word_w;
	logic [13:0] wr_dec;
	logic [15:0] len;
	logic [15:0] pr_dec;
	logic [15:0] dbytes_sub;
	logic        emit_word, word_last;
	status_t     stat_code;
	res_t        word_item, status_item;

	assign bytes.ready = !pend_q && !full;
	assign accept      = bytes.valid && bytes.ready;
	assign word_w      = {bytes.data_byte, wa_q};
	assign wr_dec      = (wr_q != 14'd0) ? wr_q - 14'd1 : wr_q;
	assign pr_dec      = (pr_q != 16'd0) ? pr_q - 16'd1 : pr_q;
	assign len         = {word_w[15:8], word_w[23:16]};
	assign dbytes_sub  = bytes.datagram_bytes - FrameOverhead;

	always_comb begin
		phase_d   = phase_q;
		bp_d      = bp_q;
		wa_d      = wa_q;
		wr_d      = wr_q;
		pr_d      = pr_q;
		ff_d      = ff_q;
		err_d     = err_q;
		emit_word = 1'b0;
		word_last = 1'b0;
		if (accept) begin
			case (phase_q)
				PhLead: begin
					if (bytes.data_byte != LeadByte) begin
						err_d   = StBadLead;
						phase_d = PhDone;
					end else if (bytes.datagram_bytes < MinDatagramBytes) begin
						err_d   = StTooShort;
						phase_d = PhDone;
					end else if ({1'b0, bytes.datagram_bytes} > MaxDatagramBytes) begin
						err_d   = StBadLength;
						phase_d = PhDone;
					end else begin
						wr_d    = dbytes_sub[15:2];
						bp_d    = 2'd1;
						phase_d = PhSkip;
					end
				end
				PhSkip: begin
					if (bp_q >= SkipLastPos) begin
						bp_d    = 2'd0;
						phase_d = (wr_q > MinWordsForFrame) ? PhHeader : PhDone;
					end else begin
						bp_d = bp_q + 2'd1;
					end
				end
				PhDone: begin
				end
				default: begin
					if (bp_q != WordLastPos) begin
						case (bp_q)
							2'd0:    wa_d[7:0]   = bytes.data_byte;
							2'd1:    wa_d[15:8]  = bytes.data_byte;
							default: wa_d[23:16] = bytes.data_byte;
						endcase
						bp_d = bp_q + 2'd1;
					end else begin
						bp_d = 2'd0;
						wr_d = wr_dec;
						case (phase_q)
							PhHeader: begin
								if (word_w[7:0] != HeaderTag) begin
									err_d   = StBadHeader;
									phase_d = PhDone;
								end else if (len < FrameOverhead || len > {2'b00, wr_dec}) begin
									err_d   = StBadLength;
									phase_d = PhDone;
								end else begin
									pr_d    = len - FrameOverhead;
									phase_d = PhBegin;
								end
							end
							PhBegin: begin
								if (word_w[31:24] != BeginTag) begin
									err_d   = StNoBegin;
									phase_d = PhDone;
								end else begin
									phase_d = (pr_q != 16'd0) ? PhPayload : PhCookie;
								end
							end
							PhPayload: begin
								pr_d      = pr_dec;
								emit_word = 1'b1;
								word_last = (pr_dec == 16'd0);
								if (pr_dec == 16'd0) begin
									phase_d = PhCookie;
								end
							end
							PhCookie: begin
								if (word_w != EndCookie) begin
									err_d   = StNoCookie;
									phase_d = PhDone;
								end else begin
									phase_d = PhEndmark;
								end
							end
							default: begin
								if (word_w[31:24] != EndTag) begin
									err_d   = StNoEnd;
									phase_d = PhDone;
								end else begin
									ff_d    = (ff_q != FrameCountMax) ? ff_q + 12'd1 : ff_q;
									phase_d = (wr_dec > MinWordsForFrame) ? PhHeader : PhDone;
								end
							end
						endcase
					end
				end
			endcase
		end

		// Final byte with the frame loop unfinished counts as bad length.
		stat_code = (err_d == StOk && phase_d != PhDone) ? StBadLength : err_d;
		status_item.kind   = KindStatus;
		status_item.word   = 32'd0;
		status_item.index  = (stat_code == StOk) ? ff_d : 12'd0;
		status_item.last   = 1'b0;
		status_item.status = stat_code;

		word_item.kind   = KindPayload;
		word_item.word   = word_w;
		word_item.index  = ff_q;
		word_item.last   = word_last;
		word_item.status = StOk;

		if (accept && bytes.last_byte) begin
			phase_d = PhLead;
			bp_d    = 2'd0;
			wr_d    = 14'd0;
			pr_d    = 16'd0;
			ff_d    = 12'd0;
			err_d   = StOk;
		end
	end

	// Word plus status on one byte: the status item waits in pend_q until the queue has room.
	assign push      = (pend_q && !full) || (accept && (emit_word || bytes.last_byte));
	assign push_data = pend_q ? pend_data_q : (emit_word ? word_item : status_item);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhLead;
			bp_q    <= 2'd0;
			wr_q    <= 14'd0;
			pr_q    <= 16'd0;
			ff_q    <= 12'd0;
			err_q   <= StOk;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			wr_q    <= wr_d;
			pr_q    <= pr_d;
			ff_q    <= ff_d;
			err_q   <= err_d;
			if (accept && emit_word && bytes.last_byte) begin
				pend_q <= 1'b1;
			end else if (pend_q && !full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_q <= wa_d;
		if (accept && emit_word && bytes.last_byte) begin
			pend_data_q <= status_item;
		end
	end

	`RDD_ASSERT(a_pend_blocks_input, pend_q |-> !bytes.ready, "byte taken while status pending")
	`RDD_ASSERT_NEXT(a_last_restarts, accept && bytes.last_byte, phase_q == PhLead && err_q == StOk, "no restart after final byte")

endmodule

@@ hdl/rdd_fifo.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rdd_pkg::res_t push_data,
	output logic          full,
	output logic          avail,
	output rdd_pkg::res_t head,
	input  logic          pop
);
	import rdd_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	res_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntFull);
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`RDD_ASSERT(a_no_overflow, push |-> !full, "queue write while full")
	`RDD_ASSERT(a_no_underflow, pop |-> avail, "queue read while empty")

endmodule

@@ hdl/rdd_emitter.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rdd_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  rdd_pkg::res_t head,
	output logic          pop,
	rdd_result_if.source  results
);
	import rdd_pkg::*;

	logic        valid_q;
	logic        kind_q;
	logic [31:0] word_q;
	logic [11:0] index_q;
	logic        last_q;
	logic [2:0]  status_q;
	logic [11:0] count_q;

	assign pop = avail && (!valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Split the shared index field by kind; unused fields go out as zero.
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head.kind;
			word_q   <= (head.kind == KindPayload) ? head.word : 32'd0;
			index_q  <= (head.kind == KindPayload) ? head.index : 12'd0;
			last_q   <= (head.kind == KindPayload) ? head.last : 1'b0;
			status_q <= (head.kind == KindStatus) ? head.status : StOk;
			count_q  <= (head.kind == KindStatus) ? head.index : 12'd0;
		end
	end

	assign results.valid           = valid_q;
	assign results.kind            = kind_q;
	assign results.payload_word    = word_q;
	assign results.readout_index   = index_q;
	assign results.last_in_readout = last_q;
	assign results.status          = status_q;
	assign results.readout_count   = count_q;

	`RDD_ASSERT(a_err_zero_count, valid_q && kind_q == KindStatus && status_q != StOk |-> count_q == 12'd0, "error status with nonzero count")

endmodule

@@ hdl/readout_datagram_deframer.sv @@
`timescale 1ns / 1ps
// Readout datagram deframer. Takes one datagram byte per transfer on bytes
// (with the datagram's total length and a final-byte flag) and streams out,
// on results, every readout payload word as soon as its fourth byte arrives,
// followed by one status item on the final byte: frame count and status 0,
// or count 0 with an error code. Words already sent are not withdrawn, so a
// consumer must hold them until the status item says the datagram was good.
// Rate: one byte per clock while the result queue has room. The one
// exception is a final byte that also completes a payload word: it yields
// two items; the status item waits in pend_q and enters the result queue
// after the word, and no byte is taken while it waits. The parser is the
// front end; a QUEUE_DEPTH-entry result queue and an output register
// decouple it from the consumer, so the byte side keeps moving while a
// finished result waits to be taken. Apart from that bubble, input ready
// drops only when the queue is full. No clearing pass after reset.
module readout_datagram_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	rdd_byte_if.sink     bytes,
	rdd_result_if.source results
);
	import rdd_pkg::*;

	// Parser to queue
	logic push;
	res_t push_data;
	logic full;

	// Queue to output stage
	logic avail;
	res_t head;
	logic pop;

	// Front end: byte-level frame walk, checks and result generation.
	rdd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// Short queue so parser and consumer stall independently.
	rdd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.avail     (avail),
		.head      (head),
		.pop       (pop)
	);

	// Back end: formats queued items into the registered result channel.
	rdd_emitter u_emitter (
		.clk     (clk),
		.arst_n  (arst_n),
		.avail   (avail),
		.head    (head),
		.pop     (pop),
		.results (results)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
	import rdd_pkg::*;

	localparam int RandomBytes   = 1750;
	localparam int DirectedRows  = 25;
	localparam int QuietBytes    = 250;  // closing stretch runs with no idling
	localparam int SettleCycles  = 16;   // result queue + output register, with slack
	localparam int MaxReports    = 100;

	// One expected transfer on the result channel.
	typedef struct {
		logic        kind;
		logic [31:0] word;
		logic [11:0] index;
		logic        last;
		status_t     status;
		logic [11:0] count;
	} readout_item_t;

	// Directed stimulus row; typed=1 pins the status item by hand.
	typedef struct {
		logic [7:0]  data;
		logic [15:0] dlen;
		logic        fin;
		logic        typed;
		status_t     status;
		logic [11:0] count;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rdd_byte_if   byte_ch();
	rdd_result_if result_ch();

	readout_datagram_deframer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.results (result_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Deframer predictor state
	// ------------------------------------------------------------------
	phase_t      dg_phase;
	logic [1:0]  byte_slot;
	logic [23:0] word_bits;      // low three bytes of the word being assembled
	logic [13:0] words_left;     // whole words still counted in the datagram
	logic [15:0] payload_left;
	logic [11:0] frames_seen;
	status_t     fault;

	readout_item_t items_due[$];
	int            mismatches;
	int            bytes_taken;   // every byte transfer since reset

	// Hand-typed expectation for the row on the wire now (directed part only).
	logic          row_typed;
	status_t       row_status;
	logic [11:0]   row_count;

	// Stimulus build area and idling knobs.
	logic [7:0]    dgram[$];
	logic [15:0]   dg_len;
	logic          scramble_len;  // later bytes carry junk datagram_bytes
	int            idle_odds;     // 0: no idling, up to 3: frequent bursts
	stim_row_t     directed_rows[0:DirectedRows-1];

	task automatic clear_state();
		dg_phase     = PhLead;
		byte_slot    = 2'd0;
		word_bits    = 24'd0;
		words_left   = 14'd0;
		payload_left = 16'd0;
		frames_seen  = 12'd0;
		fault        = StOk;
	endtask

	task automatic abort_datagram(input status_t code);
		fault    = code;
		dg_phase = PhDone;
	endtask

	task automatic next_frame_or_done();
		dg_phase = (words_left > 14'd4) ? PhHeader : PhDone;
	endtask

	// Advance the deframer by one byte and queue whatever it emits.
	task automatic parse_byte(input logic [7:0] b, input logic [15:0] dlen, input logic fin);
		logic [31:0]   w;
		logic [15:0]   flen;
		readout_item_t item;
		case (dg_phase)
			PhLead: begin
				if (b != LeadByte)
					abort_datagram(StBadLead);
				else if (dlen < MinDatagramBytes)
					abort_datagram(StTooShort);
				else begin
					words_left = 14'((dlen - 16'd3) >> 2);
					byte_slot  = 2'd1;
					dg_phase   = PhSkip;
				end
			end
			PhSkip: begin
				if (byte_slot >= 2'd2) begin
					byte_slot = 2'd0;
					next_frame_or_done();
				end else
					byte_slot = byte_slot + 2'd1;
			end
			PhDone: ;
			default: begin
				if (byte_slot < 2'd3) begin
					word_bits = word_bits | (24'(b) << (8 * byte_slot));
					byte_slot = byte_slot + 2'd1;
				end else begin
					w         = {b, word_bits};
					word_bits = 24'd0;
					byte_slot = 2'd0;
					if (words_left != 14'd0)
						words_left = words_left - 14'd1;
					case (dg_phase)
						PhHeader: begin
							// length is carried big-endian in bytes 1 and 2
							flen = {w[15:8], w[23:16]};
							if (w[7:0] != HeaderTag)
								abort_datagram(StBadHeader);
							else if (flen < 16'd3 || flen > 16'(words_left))
								abort_datagram(StBadLength);
							else begin
								payload_left = flen - 16'd3;
								dg_phase     = PhBegin;
							end
						end
						PhBegin: begin
							if (w[31:24] != BeginTag)
								abort_datagram(StNoBegin);
							else
								dg_phase = (payload_left != 16'd0) ? PhPayload : PhCookie;
						end
						PhPayload: begin
							if (payload_left != 16'd0)
								payload_left = payload_left - 16'd1;
							item = '{KindPayload, w, frames_seen, payload_left == 16'd0,
								StOk, 12'd0};
							items_due.push_back(item);
							if (payload_left == 16'd0)
								dg_phase = PhCookie;
						end
						PhCookie: begin
							if (w != EndCookie)
								abort_datagram(StNoCookie);
							else
								dg_phase = PhEndmark;
						end
						default: begin
							if (w[31:24] != EndTag)
								abort_datagram(StNoEnd);
							else begin
								if (frames_seen != FrameCountMax)
									frames_seen = frames_seen + 12'd1;
								next_frame_or_done();
							end
						end
					endcase
				end
			end
		endcase

		if (fin) begin
			// final byte before the frame loop finished counts as a length error
			if (fault == StOk && dg_phase != PhDone)
				fault = StBadLength;
			item = '{KindStatus, 32'd0, 12'd0, 1'b0, fault,
				(fault == StOk) ? frames_seen : 12'd0};
			if (row_typed) begin
				item.status = row_status;
				item.count  = row_count;
			end
			items_due.push_back(item);
			clear_state();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (mismatches < MaxReports)
			$display("mismatch %s: got %0h, want %0h", what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// Monitor: input transfers feed the predictor, output transfers are
	// checked against the oldest queued expectation. Both handled in one
	// block so ordering within the edge can't matter.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		readout_item_t due;
		if (arst_n === 1'b1) begin
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
				bytes_taken++;
				parse_byte(byte_ch.data_byte, byte_ch.datagram_bytes, byte_ch.last_byte);
			end
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (items_due.size() == 0)
					flag_mismatch("result with nothing due, word", result_ch.payload_word, 0);
				else begin
					due = items_due.pop_front();
					if (result_ch.kind !== due.kind)
						flag_mismatch("kind", result_ch.kind, due.kind);
					if (result_ch.payload_word !== due.word)
						flag_mismatch("payload_word", result_ch.payload_word, due.word);
					if (result_ch.readout_index !== due.index)
						flag_mismatch("readout_index", result_ch.readout_index, due.index);
					if (result_ch.last_in_readout !== due.last)
						flag_mismatch("last_in_readout", result_ch.last_in_readout, due.last);
					if (result_ch.status !== due.status)
						flag_mismatch("status", result_ch.status, due.status);
					if (result_ch.readout_count !== due.count)
						flag_mismatch("readout_count", result_ch.readout_count, due.count);
				end
			end
		end
	end

	// Consumer side: ready drops in bursts, at a rate set by idle_odds.
	initial begin
		int stall_left;
		result_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left != 0)
				stall_left--;
			else if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
				result_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 6) - 1;
			end else
				result_ch.ready = 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Called on a falling edge; returns on the falling edge after the transfer.
	task automatic send_byte(input logic [7:0] b, input logic [15:0] dlen, input logic fin,
		input logic typed, input status_t st, input logic [11:0] cnt);
		if (idle_odds != 0 && $urandom_range(0, 9) < idle_odds) begin
			byte_ch.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		byte_ch.valid          = 1'b1;
		byte_ch.data_byte      = b;
		byte_ch.datagram_bytes = dlen;
		byte_ch.last_byte      = fin;
		row_typed  = typed;
		row_status = st;
		row_count  = cnt;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic send_datagram();
		int i;
		for (i = 0; i < dgram.size(); i++)
			send_byte(dgram[i], (i == 0 || !scramble_len) ? dg_len : 16'($urandom),
				i == dgram.size() - 1, 1'b0, StOk, 12'd0);
	endtask

	task automatic drain_results();
		while (items_due.size() != 0) @(negedge clk);
	endtask

	// Words go out little-endian.
	task automatic push_word(input logic [31:0] w);
		dgram.push_back(w[7:0]);
		dgram.push_back(w[15:8]);
		dgram.push_back(w[23:16]);
		dgram.push_back(w[31:24]);
	endtask

	// One readout frame of length flen (flen + 1 words on the wire).
	task automatic add_frame(input int flen);
		logic [15:0] fl;
		int          sel;
		fl = 16'(flen);
		push_word({8'($urandom), fl[7:0], fl[15:8], HeaderTag});
		push_word({BeginTag, 24'($urandom)});
		repeat (flen - 3) begin
			sel = $urandom_range(0, 7);
			push_word(sel == 0 ? 32'h0 : (sel == 1 ? 32'hffffffff : $urandom));
		end
		push_word(EndCookie);
		push_word({EndTag, 24'($urandom)});
	endtask

	// Mostly well-formed datagrams with random content; the rest are noise or
	// get broken after the fact (bit flip, cut short, wrong length, overrun, junk later lengths).
	task automatic make_datagram();
		int pick, nfr, at;
		dgram.delete();
		scramble_len = 1'b0;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			dgram.push_back($urandom_range(0, 1) ? LeadByte : 8'($urandom));
			repeat ($urandom_range(0, 30)) dgram.push_back(8'($urandom));
			dg_len = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 40));
			scramble_len = $urandom_range(0, 1);
			return;
		end
		dgram.push_back(LeadByte);
		dgram.push_back(8'($urandom));
		dgram.push_back(8'($urandom));
		nfr = $urandom_range(1, 3);
		repeat (nfr)
			add_frame(($urandom_range(0, 9) == 0) ? $urandom_range(3, 40) : $urandom_range(3, 8));
		// tail of at most four whole words, so no further header is expected
		repeat ($urandom_range(0, 19)) dgram.push_back(8'($urandom));
		dg_len = 16'(dgram.size());
		if (pick >= 70) begin
			case (pick % 5)
				0: begin
					at = $urandom_range(0, dgram.size() - 1);
					dgram[at] = dgram[at] ^ (8'd1 << $urandom_range(0, 7));
				end
				1: repeat ($urandom_range(1, dgram.size() - 1)) void'(dgram.pop_back());
				2: dg_len = $urandom_range(0, 1) ? 16'($urandom_range(0, dgram.size() + 40))
					: 16'($urandom_range(0, 65535));
				3: repeat ($urandom_range(1, 12)) dgram.push_back(8'($urandom));
				default: scramble_len = 1'b1;
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int r, dg_count;
		arst_n                 = 1'b0;
		byte_ch.valid          = 1'b0;
		byte_ch.data_byte      = 8'd0;
		byte_ch.datagram_bytes = 16'd0;
		byte_ch.last_byte      = 1'b0;
		row_typed              = 1'b0;
		row_status             = StOk;
		row_count              = 12'd0;
		mismatches             = 0;
		bytes_taken            = 0;
		idle_odds              = 2;
		scramble_len           = 1'b0;
		dg_len                 = 16'd0;
		clear_state();

		directed_rows = '{
			// one-byte datagrams at the field extremes
			'{8'h00,    16'd0,     1'b1, 1'b1, StBadLead,   12'd0},
			'{8'hff,    16'hffff,  1'b1, 1'b1, StBadLead,   12'd0},
			'{LeadByte, 16'd0,     1'b1, 1'b1, StTooShort,  12'd0},
			'{LeadByte, 16'd18,    1'b1, 1'b1, StTooShort,  12'd0},
			// good lead and size, but the datagram ends right away
			'{LeadByte, 16'd19,    1'b1, 1'b1, StBadLength, 12'd0},
			'{LeadByte, 16'hffff,  1'b1, 1'b1, StBadLength, 12'd0},
			// smallest good size: 19 bytes hold only four words, too few to
			// open a frame, so the frame-shaped bytes are tail: ok, no frames
			'{LeadByte, 16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'hff,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h00,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h58,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h00,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h03,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'ha5,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h00,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'hff,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h5a,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'hbb,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h21,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h43,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h65,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h87,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h12,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h34,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'h56,    16'd19, 1'b0, 1'b0, StOk, 12'd0},
			'{8'hee,    16'd19, 1'b1, 1'b1, StOk, 12'd0}
		};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < DirectedRows; r++)
			send_byte(directed_rows[r].data, directed_rows[r].dlen, directed_rows[r].fin,
				directed_rows[r].typed, directed_rows[r].status, directed_rows[r].count);

		// hold off the sender until the block has emptied
		byte_ch.valid = 1'b0;
		drain_results();

		// random datagrams; the closing stretch runs at full rate on both sides
		dg_count = 0;
		while (bytes_taken < DirectedRows + RandomBytes) begin
			idle_odds = (bytes_taken < DirectedRows + RandomBytes - QuietBytes)
				? $urandom_range(0, 3) : 0;
			make_datagram();
			send_datagram();
			dg_count++;
			if (dg_count % 30 == 0) begin
				byte_ch.valid = 1'b0;
				drain_results();
			end
		end
		byte_ch.valid = 1'b0;

		drain_results();
		repeat (SettleCycles) @(negedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run with every stall maxed out.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rdd_pkg.sv
hdl/rdd_byte_if.sv
hdl/rdd_result_if.sv
hdl/rdd_parser.sv
hdl/rdd_fifo.sv
hdl/rdd_emitter.sv
hdl/readout_datagram_deframer.sv
tb/tb_top.sv
